// ===== sv/tha_pkg.sv =====
// Shared types and constants for the track heading averager.
// No dependencies; imported by every module of the block.
package tha_pkg;

   localparam int SUM_W       = 48;   // exact window sums, depth up to 64
   localparam int DIV_W       = 11;   // (2r+1)*(n-2r) divisor
   localparam int CW          = 45;   // CORDIC vector width
   localparam int ZW          = 24;   // CORDIC angle, Q.20 radians
   localparam int CORDIC_ITER = 20;
   localparam int NORM_BIT    = 40;
   localparam logic signed [ZW-1:0] PI_Q20    = 24'sd3294199;
   localparam logic        [15:0]   YAW_LIMIT = 16'd12868;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_WALK_XY, ST_DIVX_GO, ST_DIVX_WAIT, ST_DIVY_GO,
      ST_DIVY_WAIT, ST_VEC_LOAD, ST_NORM, ST_CORDIC, ST_ROUND, ST_WALK_YAW,
      ST_DIVA_GO, ST_DIVA_WAIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic walk_clr;
      logic acc_xy;
      logic acc_yaw;
      logic div_start;
      logic div_sel_y;
      logic cap_mx;
      logic cap_my;
      logic vec_load;
      logic norm_step;
      logic cordic_step;
      logic yaw_write;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic enough;
      logic walk_last;
      logic div_done;
      logic norm_done;
      logic vec_zero;
      logic cordic_last;
   } status_type;

   function automatic logic [ZW-1:0] atan_q20(input logic [4:0] i);
      logic [ZW-1:0] v;
      unique case (i)
         5'd0:    v = 24'd823550;
         5'd1:    v = 24'd486170;
         5'd2:    v = 24'd256879;
         5'd3:    v = 24'd130396;
         5'd4:    v = 24'd65451;
         5'd5:    v = 24'd32757;
         5'd6:    v = 24'd16383;
         5'd7:    v = 24'd8192;
         5'd8:    v = 24'd4096;
         5'd9:    v = 24'd2048;
         5'd10:   v = 24'd1024;
         5'd11:   v = 24'd512;
         5'd12:   v = 24'd256;
         5'd13:   v = 24'd128;
         5'd14:   v = 24'd64;
         5'd15:   v = 24'd32;
         5'd16:   v = 24'd16;
         5'd17:   v = 24'd8;
         5'd18:   v = 24'd4;
         5'd19:   v = 24'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/tha_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on tha_pkg for widths.
module tha_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [tha_pkg::SUM_W-1:0] dividend,
   input  logic        [tha_pkg::DIV_W-1:0] divisor,
   output logic signed [tha_pkg::SUM_W-1:0] quotient,
   output logic                         done
);
   import tha_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W+1:0] trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[SUM_W-1]};
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         dvd_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b00, dsr_ff}) begin
            rem_in = (DIV_W+1)'(trial - {2'b00, dsr_ff});
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W:0];
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = neg_ff ? SUM_W'(-$signed(dvd_ff)) : $signed(dvd_ff);
   assign done     = done_ff;

endmodule

// ===== sv/tha_dp.sv =====
// Datapath: position and yaw histories, window walk, divider, CORDIC.
// Depends on tha_pkg and tha_div.
module tha_dp #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  tha_pkg::cmd_type    cmd,
   output tha_pkg::status_type status,
   input  logic signed [31:0]  req_x_pos,
   input  logic signed [31:0]  req_y_pos,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_write_data,
   output logic signed [14:0]  rsp_heading_avg,
   output logic                rsp_history_enough
);
   import tha_pkg::*;

   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CNT_W  = (IDX_W > 5) ? IDX_W : 5;

   logic signed [31:0] x_hist_ff [HISTORY_DEPTH];
   logic signed [31:0] y_hist_ff [HISTORY_DEPTH];
   logic signed [15:0] yaw_hist_ff [HISTORY_DEPTH];
   logic [FILL_W-1:0]  fill_ff;
   logic [2:0]         r_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic signed [SUM_W-1:0] acc_x_ff, acc_y_ff;
   logic signed [31:0] mx_ff, my_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [ZW-1:0] cz_ff, cz_in;
   logic               zero_ff;
   logic signed [14:0] heading_ff;
   logic               enough_ff;

   // window coverage count of sample j
   logic [7:0] nn, rr, jj, lo, hi;
   logic [3:0] cov;
   logic [IDX_W-1:0] jidx;
   logic signed [36:0] prod_x, prod_y;
   logic signed [20:0] prod_yaw;
   logic [DIV_W-1:0] dsr_wide;
   logic signed [SUM_W-1:0] quo;
   logic div_done;

   assign nn   = 8'(fill_ff);
   assign rr   = {5'd0, r_ff};
   assign jidx = cnt_ff[IDX_W-1:0];
   assign jj   = 8'(jidx);

   always_comb begin
      lo  = (jj >= 8'(rr << 1)) ? 8'(jj - rr) : rr;
      hi  = (8'(jj + rr) <= 8'(nn - rr - 8'd1)) ? 8'(jj + rr) : 8'(nn - rr - 8'd1);
      cov = 4'(hi - lo + 8'd1);
   end

   assign prod_x   = x_hist_ff[jidx] * $signed({1'b0, cov});
   assign prod_y   = y_hist_ff[jidx] * $signed({1'b0, cov});
   assign prod_yaw = yaw_hist_ff[jidx] * $signed({1'b0, cov});
   assign dsr_wide = DIV_W'({r_ff, 1'b1}) * DIV_W'(nn - (rr << 1));

   tha_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel_y ? acc_y_ff : acc_x_ff),
      .divisor  (dsr_wide),
      .quotient (quo),
      .done     (div_done)
   );

   // vector load, normalise and CORDIC rotation
   logic signed [33:0] vx, vy;
   logic signed [CW-1:0] abs_cy;
   logic [4:0] it;
   logic signed [ZW-1:0] tz;
   logic [ZW-1:0] mag;
   logic [15:0] q, qc;
   logic signed [15:0] yaw_q;

   assign vx     = 34'(y_hist_ff[0]) - 34'(my_ff);
   assign vy     = 34'(x_hist_ff[0]) - 34'(mx_ff);
   assign abs_cy = cy_ff[CW-1] ? -cy_ff : cy_ff;
   assign it     = cnt_ff[4:0];
   assign tz     = $signed(atan_q20(it));

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (cmd.vec_load) begin
         cz_in = '0;
         if (vx < 0) begin
            cz_in = (vy >= 0) ? PI_Q20 : -PI_Q20;
            cx_in = -CW'(vx);
            cy_in = -CW'(vy);
         end else begin
            cx_in = CW'(vx);
            cy_in = CW'(vy);
         end
      end else if (cmd.norm_step) begin
         cx_in = cx_ff <<< 1;
         cy_in = cy_ff <<< 1;
      end else if (cmd.cordic_step) begin
         if (cy_ff > 0) begin
            cx_in = cx_ff + (cy_ff >>> it);
            cy_in = cy_ff - (cx_ff >>> it);
            cz_in = cz_ff + tz;
         end else begin
            cx_in = cx_ff - (cy_ff >>> it);
            cy_in = cy_ff + (cx_ff >>> it);
            cz_in = cz_ff - tz;
         end
      end
   end

   // round Q.20 to Q4.12, half away from zero, then clamp
   always_comb begin
      mag   = cz_ff[ZW-1] ? ZW'(-cz_ff) : ZW'(cz_ff);
      q     = 16'((mag + ZW'(128)) >> 8);
      qc    = (q > YAW_LIMIT) ? YAW_LIMIT : q;
      yaw_q = cz_ff[ZW-1] ? -$signed(qc) : $signed(qc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         r_ff    <= 3'd2;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            x_hist_ff[i]   <= '0;
            y_hist_ff[i]   <= '0;
            yaw_hist_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en)
            r_ff <= csr_write_data;
         if (cmd.push) begin
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               x_hist_ff[i]   <= x_hist_ff[i-1];
               y_hist_ff[i]   <= y_hist_ff[i-1];
               yaw_hist_ff[i] <= yaw_hist_ff[i-1];
            end
            x_hist_ff[0] <= req_x_pos;
            y_hist_ff[0] <= req_y_pos;
            if (fill_ff != FILL_W'(HISTORY_DEPTH))
               fill_ff <= FILL_W'(fill_ff + 1'b1);
         end
         if (cmd.yaw_write)
            yaw_hist_ff[0] <= yaw_q;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_clr) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (cmd.acc_xy) begin
         acc_x_ff <= acc_x_ff + SUM_W'(prod_x);
         acc_y_ff <= acc_y_ff + SUM_W'(prod_y);
      end else if (cmd.acc_yaw) begin
         acc_x_ff <= acc_x_ff + SUM_W'(prod_yaw);
      end
      if (cmd.walk_clr || cmd.vec_load)
         cnt_ff <= '0;
      else if (cmd.acc_xy || cmd.acc_yaw || cmd.cordic_step)
         cnt_ff <= CNT_W'(cnt_ff + 1'b1);
      if (cmd.cap_mx) mx_ff <= quo[31:0];
      if (cmd.cap_my) my_ff <= quo[31:0];
      if (cmd.vec_load) zero_ff <= (vx == 0) && (vy == 0);
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      if (cmd.load_out) begin
         enough_ff  <= status.enough;
         heading_ff <= status.enough ? quo[14:0] : '0;
      end
   end

   always_comb begin
      status.enough      = nn > 8'((rr << 1) + 8'd1);
      status.walk_last   = 8'(jidx) == 8'(nn - 8'd1);
      status.div_done    = div_done;
      status.norm_done   = zero_ff || (|cx_ff[CW-1:NORM_BIT]) || (|abs_cy[CW-1:NORM_BIT]);
      status.vec_zero    = zero_ff;
      status.cordic_last = it == 5'(CORDIC_ITER - 1);
   end

   assign rsp_heading_avg    = heading_ff;
   assign rsp_history_enough = enough_ff;

endmodule

// ===== sv/tha_ctrl.sv =====
// Controller: sequences push, window walks, divisions and CORDIC.
// Depends on tha_pkg.
module tha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tha_pkg::status_type status,
   output tha_pkg::cmd_type    cmd
);
   import tha_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.walk_clr = 1'b1;
            state_in = status.enough ? ST_WALK_XY : ST_DONE;
         end
         ST_WALK_XY: begin
            cmd.acc_xy = 1'b1;
            if (status.walk_last) state_in = ST_DIVX_GO;
         end
         ST_DIVX_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVX_WAIT;
         end
         ST_DIVX_WAIT: begin
            if (status.div_done) begin
               cmd.cap_mx = 1'b1;
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = ST_DIVY_WAIT;
         end
         ST_DIVY_WAIT: begin
            if (status.div_done) begin
               cmd.cap_my = 1'b1;
               state_in = ST_VEC_LOAD;
            end
         end
         ST_VEC_LOAD: begin
            cmd.vec_load = 1'b1;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.vec_zero) state_in = ST_ROUND;
            else if (status.norm_done) state_in = ST_CORDIC;
            else cmd.norm_step = 1'b1;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.yaw_write = 1'b1;
            cmd.walk_clr  = 1'b1;
            state_in = ST_WALK_YAW;
         end
         ST_WALK_YAW: begin
            cmd.acc_yaw = 1'b1;
            if (status.walk_last) state_in = ST_DIVA_GO;
         end
         ST_DIVA_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVA_WAIT;
         end
         ST_DIVA_WAIT: begin
            if (status.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
   a_push_checks: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> state_ff == ST_CHECK)
      else $error("push not followed by history check");
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider finished without iterating");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE && !cmd.cordic_step)
      else $error("input taken while busy");

endmodule

// ===== sv/track_heading_averager.sv =====
// Track heading averager: pushes x/y samples, derives a heading by CORDIC
// and returns the windowed mean of the heading history.
// With a short history the result follows the check; otherwise the x/y walk,
// two divisions, normalise, CORDIC, heading walk and a third division come first.
// A new sample is taken only in idle; one 48-step divider serves all three.
// Reset (synchronous): histories cleared, fill count zero, half width 2.
module track_heading_averager #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_x_pos,
   input  logic signed [31:0] req_y_pos,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [14:0] rsp_heading_avg,
   output logic               rsp_history_enough,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_write_data
);
   import tha_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: hold the state machine and the result valid flag
   tha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: histories, walk accumulators, divider and CORDIC
   tha_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_x_pos          (req_x_pos),
      .req_y_pos          (req_y_pos),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_heading_avg    (rsp_heading_avg),
      .rsp_history_enough (rsp_history_enough)
   );

endmodule

// ===== tb/tb_track_heading_averager.sv =====
// Testbench for track_heading_averager: a scoreboard class predicts and checks
// the averaged heading of each transfer. Depends on the DUT only (tha_pkg is not needed).
`timescale 1ns / 1ps

module tb_track_heading_averager;

   localparam int DEPTH = 16;

   typedef struct {
      logic signed [14:0] heading;
      bit                 enough;
   } heading_result_type;

   // Prediction and checking of heading results
   class heading_scoreboard;
      int               x_hist[DEPTH];
      int               y_hist[DEPTH];
      int               yaw_hist[DEPTH];
      int unsigned      fill;
      int unsigned      half_width;
      heading_result_type awaited[$];
      int               errors;
      int               checked;
      int               enough_seen;
      longint           atan_tab[20] = '{823550, 486170, 256879, 130396, 65451,
         32757, 16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

      function new();
         foreach (x_hist[i]) begin
            x_hist[i] = 0;
            y_hist[i] = 0;
            yaw_hist[i] = 0;
         end
         fill = 0;
         half_width = 2;
         errors = 0;
         checked = 0;
         enough_seen = 0;
      endfunction

      function void set_half_width(int unsigned w);
         half_width = w & 7;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function longint window_mean(ref int h[DEPTH], input int unsigned n,
                                   input int unsigned w);
         longint sum;
         longint div;
         sum = 0;
         div = longint'(2 * w + 1) * longint'(n - 2 * w);
         for (int unsigned i = w; i < n - w; i++)
            for (int unsigned j = i - w; j <= i + w; j++)
               sum += h[j];
         return sum / div;
      endfunction

      // Fixed CORDIC vectoring, Q.20 angle rounded to Q4.12
      function longint heading_q12(longint vx, longint vy);
         longint z;
         longint ax;
         longint ay;
         longint m;
         longint dx;
         longint dy;
         longint mag;
         longint q;
         z = 0;
         if (vx == 0 && vy == 0) return 0;
         if (vx < 0) begin
            z = (vy >= 0) ? 64'sd3294199 : -64'sd3294199;
            vx = -vx;
            vy = -vy;
         end
         ax = vx;
         ay = (vy < 0) ? -vy : vy;
         m = (ax > ay) ? ax : ay;
         while (m < (64'sd1 << 40)) begin
            m = m * 2;
            vx = vx * 2;
            vy = vy * 2;
         end
         for (int i = 0; i < 20; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
               vx += dx; vy -= dy; z += atan_tab[i];
            end else begin
               vx -= dx; vy += dy; z -= atan_tab[i];
            end
         end
         mag = (z < 0) ? -z : z;
         q = (mag + 128) >>> 8;
         if (q > 12868) q = 12868;
         return (z < 0) ? -q : q;
      endfunction

      // Note an accepted position and queue the heading it should produce
      function void note_input(int xp, int yp);
         heading_result_type res;
         longint mx;
         longint my;
         longint yaw;
         for (int i = DEPTH - 1; i > 0; i--) begin
            x_hist[i] = x_hist[i - 1];
            y_hist[i] = y_hist[i - 1];
            yaw_hist[i] = yaw_hist[i - 1];
         end
         x_hist[0] = xp;
         y_hist[0] = yp;
         if (fill < DEPTH) fill++;
         if (fill <= 2 * half_width + 1) begin
            res.heading = '0;
            res.enough = 0;
         end else begin
            mx = window_mean(x_hist, fill, half_width);
            my = window_mean(y_hist, fill, half_width);
            yaw = heading_q12(longint'(y_hist[0]) - my, longint'(x_hist[0]) - mx);
            yaw_hist[0] = int'(yaw);
            res.heading = 15'(window_mean(yaw_hist, fill, half_width));
            res.enough = 1;
         end
         awaited.insert(awaited.size(), res);
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(logic signed [14:0] heading, logic enough);
         heading_result_type exp_res;
         checked++;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing awaited (heading %0d)", heading));
            return;
         end
         exp_res = awaited.pop_front();
         if (enough) enough_seen++;
         if (enough !== exp_res.enough)
            report($sformatf("history_enough %b, predicted %b", enough, exp_res.enough));
         if (heading !== exp_res.heading)
            report($sformatf("heading_avg %0d, predicted %0d", heading, exp_res.heading));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_x_pos;
   logic signed [31:0] req_y_pos;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [14:0] rsp_heading_avg;
   logic               rsp_history_enough;
   logic               csr_write_en;
   logic [2:0]         csr_write_data;

   heading_scoreboard sb;
   int  burst_left;
   int  sent;
   bit  hold_go;
   int  hold_left;
   int  rx_mode;
   int  rx_mode_left;
   int  track_x;
   int  track_y;
   int  step_x;
   int  step_y;

   track_heading_averager #(.HISTORY_DEPTH(DEPTH)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_pos          (req_x_pos),
      .req_y_pos          (req_y_pos),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_heading_avg    (rsp_heading_avg),
      .rsp_history_enough (rsp_history_enough),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Receiver: stall in random modes; on request, hold off for a long stretch so
   // the block fills up and backs up its input
   initial begin
      rsp_ready = 0;
      hold_left = 0;
      rx_mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 0;
            hold_left = 1500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               rx_mode_left = $urandom_range(8, 64);
            end
            rx_mode_left--;
            case (rx_mode)
               0: rsp_ready <= 1;
               1: rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Sample results at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_heading_avg, rsp_history_enough);
   end

   // Offer one position; called and returns at a falling edge. Bursts of random
   // length with random gaps between them.
   task automatic send_position(int xp, int yp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_x_pos <= xp;
      req_y_pos <= yp;
      do @(posedge clock); while (!req_ready);
      sb.note_input(xp, yp);
      sent++;
      @(negedge clock);
   endtask

   // Write the half width only with nothing in flight
   task automatic write_half_width(int unsigned w);
      req_valid <= 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_write_en <= 1;
      csr_write_data <= w[2:0];
      @(negedge clock);
      csr_write_en <= 0;
      sb.set_half_width(w);
   endtask

   // Mostly smooth tracks with random heading and step size; some wild noise
   // and some stationary runs for the zero-vector case
   task automatic random_position();
      int kind;
      int sh;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         send_position($urandom, $urandom);
      end else if (kind == 1) begin
         send_position(track_x, track_y);
      end else begin
         if ($urandom_range(0, 19) == 0) begin
            sh = $urandom_range(0, 28);
            track_x = $urandom >>> $urandom_range(0, 3);
            track_y = $urandom >>> $urandom_range(0, 3);
            step_x = int'($urandom) >>> (31 - sh);
            step_y = int'($urandom) >>> (31 - sh);
         end
         track_x += step_x + $signed($urandom_range(0, 6)) - 3;
         track_y += step_y + $signed($urandom_range(0, 6)) - 3;
         send_position(track_x, track_y);
      end
   endtask

   initial begin
      int unsigned widths[8];
      widths = '{0, 7, 3, 1, 5, 6, 4, 2};
      sb = new();
      reset = 1;
      req_valid = 0;
      req_x_pos = '0;
      req_y_pos = '0;
      csr_write_en = 0;
      csr_write_data = '0;
      hold_go = 0;
      burst_left = 0;
      sent = 0;
      track_x = 0; track_y = 0; step_x = 100; step_y = -50;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: reset width of 2, field extremes, stationary point, all
      // quadrants including the left half plane on both sides of the axis
      send_position(32'sh7fffffff, 32'sh7fffffff);
      send_position(32'sh80000000, 32'sh80000000);
      send_position(32'sh7fffffff, 32'sh80000000);
      send_position(32'sh80000000, 32'sh7fffffff);
      send_position(0, 0);
      send_position(0, 0);
      send_position(-1, -1);
      for (int i = 0; i < 6; i++) send_position(5, 5);
      send_position(1000, 0);
      send_position(-1000, 0);
      send_position(0, 1000);
      send_position(0, -1000);
      send_position(-2000, 3);
      send_position(-2000, -3);
      send_position(32'sh7fffffff, 0);
      send_position(0, 32'sh80000000);
      send_position(1, 1);

      for (int ph = 0; ph < 8; ph++) begin
         write_half_width(widths[ph]);
         if (ph == 2) begin
            // long receiver hold-off while items keep arriving
            @(posedge clock);
            hold_go = 1;
            @(negedge clock);
         end
         for (int k = 0; k < 105; k++) random_position();
      end
      req_valid <= 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d positions over all 8 half widths, %0d results (%0d with heading)",
               sent, sb.checked, sb.enough_seen);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tha_pkg.sv
sv/tha_div.sv
sv/tha_dp.sv
sv/tha_ctrl.sv
sv/track_heading_averager.sv
tb/tb_track_heading_averager.sv
